>>> src/differential_drive_mixer_unit_macros.svh
// Assertion macros for the differential drive mixer RTL, used by ddm_queue.
// Each macro expects clk and rst in scope where it is used.
`ifndef DIFFERENTIAL_DRIVE_MIXER_UNIT_MACROS_SVH
`define DIFFERENTIAL_DRIVE_MIXER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define DDM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define DDM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/ddm_pkg.sv
// Package for the differential drive mixer: widths, constants, beat types
// and the divide-by-thousand helper. No dependencies.
`default_nettype none

package ddm_pkg;

  // Fixed-point unit: thousandths
  localparam int UNIT        = 1000;
  localparam int MAG_W       = 10;   // magnitudes up to 1000
  localparam int VAL_W       = 11;   // signed values -1000..1000
  localparam int DEN_W       = 11;   // |x|+|y| up to 2000
  localparam int NUM_W       = 20;   // |x|*1000 up to 1e6
  localparam int CORR_W      = 11;
  localparam int DUTY_W      = 11;
  localparam int PROD_W      = 21;   // products fed to the /1000 helper
  localparam int SUM_W       = 22;   // signed blend sums
  localparam int CMD_W       = 16;

  // Ratio divider: 10 quotient bits, two per pipeline stage
  localparam int Q_W            = 10;
  localparam int BITS_PER_STAGE = 2;
  localparam int DIV_STAGES     = Q_W / BITS_PER_STAGE;

  // Queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // Reciprocal of 1000: exact floor for every n below 2^21
  localparam logic [21:0] RECIP       = 22'd2147484;
  localparam int          RECIP_SHIFT = 31;

  // Configuration register indexes
  localparam int INDEX_W = 1;
  localparam logic [INDEX_W-1:0] REG_LEFT_CORR  = 1'd0;
  localparam logic [INDEX_W-1:0] REG_RIGHT_CORR = 1'd1;
  localparam logic [CORR_W-1:0]  CORR_RESET     = 11'd1000;

  // Classified command handed from front to back
  typedef struct packed {
    logic signed [VAL_W-1:0] x;
    logic [MAG_W-1:0]        ax;
    logic [MAG_W-1:0]        ay;
    logic [DEN_W-1:0]        den;
    logic [NUM_W-1:0]        num;
    logic                    x_pos;
    logic                    y_pos;
    logic                    y_neg;
  } cmd_t;

  // Motor driver result of one command
  typedef struct packed {
    logic              right_in_two;
    logic              right_in_one;
    logic [DUTY_W-1:0] right_duty;
    logic              left_in_two;
    logic              left_in_one;
    logic [DUTY_W-1:0] left_duty;
  } result_t;

  // floor(n / 1000) through a reciprocal multiply
  function automatic logic [DUTY_W-1:0] div_unit(input logic [PROD_W-1:0] n);
    logic [PROD_W+21:0] p;
    p = (PROD_W+22)'(n) * (PROD_W+22)'(RECIP);
    return p[RECIP_SHIFT +: DUTY_W];
  endfunction

endpackage

`default_nettype wire

>>> src/ddm_front.sv
// Front end of the mixer: accepts a command beat, clamps and classifies it.
// Depends on ddm_pkg.
`default_nettype none

module ddm_front import ddm_pkg::*; #(
  parameter int FULL_SCALE = 1000
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic signed [CMD_W-1:0]  turn_cmd,
  input  wire logic signed [CMD_W-1:0]  throttle_cmd,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output cmd_t                          out_cmd
);

  localparam logic signed [CMD_W-1:0] FS_POS = CMD_W'(FULL_SCALE);
  localparam logic signed [CMD_W-1:0] FS_NEG = -FS_POS;

  logic signed [CMD_W-1:0] x_clamp, y_clamp;
  logic signed [VAL_W-1:0] x, y, x_neg, y_neg;
  cmd_t                    cmd_next;
  logic                    load;

  // Clamp both commands to full scale
  always_comb begin
    if (turn_cmd > FS_POS)          x_clamp = FS_POS;
    else if (turn_cmd < FS_NEG)     x_clamp = FS_NEG;
    else                            x_clamp = turn_cmd;
    if (throttle_cmd > FS_POS)      y_clamp = FS_POS;
    else if (throttle_cmd < FS_NEG) y_clamp = FS_NEG;
    else                            y_clamp = throttle_cmd;
  end

  assign x     = x_clamp[VAL_W-1:0];
  assign y     = y_clamp[VAL_W-1:0];
  assign x_neg = -x;
  assign y_neg = -y;

  // Magnitudes, ratio operands and sign flags
  always_comb begin
    cmd_next.x     = x;
    cmd_next.ax    = x[VAL_W-1] ? x_neg[MAG_W-1:0] : x[MAG_W-1:0];
    cmd_next.ay    = y[VAL_W-1] ? y_neg[MAG_W-1:0] : y[MAG_W-1:0];
    cmd_next.den   = {1'b0, cmd_next.ax} + {1'b0, cmd_next.ay};
    cmd_next.num   = NUM_W'(cmd_next.ax) * NUM_W'(UNIT);
    cmd_next.x_pos = !x[VAL_W-1] && (x != '0);
    cmd_next.y_pos = !y[VAL_W-1] && (y != '0);
    cmd_next.y_neg = y[VAL_W-1];
  end

  // Holding register: free when empty or when the queue takes it
  assign in_ready = !out_valid || out_ready;
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_cmd <= cmd_next;
    end
  end

endmodule

`default_nettype wire

>>> src/ddm_queue.sv
// Short queue between the mixer front and back ends.
// Depends on ddm_pkg and the assertion macro header.
`default_nettype none
`include "differential_drive_mixer_unit_macros.svh"

module ddm_queue import ddm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  cmd_t      in_cmd,
  output logic      out_valid,
  input  wire logic out_ready,
  output cmd_t      out_cmd
);

  cmd_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push, pop;

  assign in_ready  = count != QCNT_W'(QDEPTH);
  assign out_valid = count != '0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_cmd   = entries[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (!push && pop) count <= count - 1'b1;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_cmd;
    end
  end

  `DDM_ASSERT_IMPL(a_count_range, 1'b1, count <= QCNT_W'(QDEPTH), "queue count out of range")
  `DDM_ASSERT_NEXT(a_count_up, push && !pop, count == $past(count) + 2'd1, "count missed a push")
  `DDM_ASSERT_NEXT(a_count_down, !push && pop, count == $past(count) - 2'd1, "count missed a pop")
  `DDM_ASSERT_NEXT(a_count_hold, push == pop, count == $past(count), "count moved without cause")

endmodule

`default_nettype wire

>>> src/ddm_back.sv
// Back end of the mixer: ratio divider, arc/tank blend and duty scaling,
// one stalling pipeline ending in the output register. Depends on ddm_pkg.
`default_nettype none

module ddm_back import ddm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  cmd_t                   in_cmd,
  input  wire logic [CORR_W-1:0] left_corr,
  input  wire logic [CORR_W-1:0] right_corr,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output result_t                out_res
);

  typedef struct packed {
    cmd_t             cmd;
    logic [NUM_W-1:0] rem;
    logic [Q_W-1:0]   q;
  } div_t;

  localparam int QIDX_W = $clog2(Q_W);

  logic adv;

  // Whole pipeline moves unless the output register is full and held
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Restoring divider: |x|*1000 / (|x|+|y|), two quotient bits per stage
  div_t                  div_src [DIV_STAGES];
  div_t                  div_nxt [DIV_STAGES];
  div_t                  div_r   [DIV_STAGES];
  logic [DIV_STAGES-1:0] div_v;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    if (s == 0) begin : g_head
      assign div_src[s] = {in_cmd, in_cmd.num, Q_W'(0)};
    end else begin : g_link
      assign div_src[s] = div_r[s-1];
    end

    always_comb begin
      div_t               d;
      logic [NUM_W:0]     sh;
      logic [QIDX_W-1:0]  k;
      d = div_src[s];
      for (int j = 0; j < BITS_PER_STAGE; j++) begin
        k  = QIDX_W'(Q_W - 1 - (s * BITS_PER_STAGE + j));
        sh = (NUM_W+1)'(d.cmd.den) << k;
        if ({1'b0, d.rem} >= sh) begin
          d.rem  = NUM_W'({1'b0, d.rem} - sh);
          d.q[k] = 1'b1;
        end
      end
      div_nxt[s] = d;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        div_r[s] <= div_nxt[s];
      end
    end
  end

  // Divider valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      div_v <= '0;
    end else if (adv) begin
      div_v <= {div_v[DIV_STAGES-2:0], in_valid};
    end
  end

  // Stage A: slow-wheel product |y| * (1000 - t)
  div_t              div_last;
  logic [MAG_W-1:0]  t;
  logic              a_v;
  cmd_t              a_cmd;
  logic [NUM_W-1:0]  a_prod;

  assign div_last = div_r[DIV_STAGES-1];
  assign t        = (div_last.cmd.den == '0) ? '0 : div_last.q;

  always_ff @(posedge clk) begin
    if (adv) begin
      a_cmd  <= div_last.cmd;
      a_prod <= NUM_W'(div_last.cmd.ay) * (NUM_W'(UNIT) - NUM_W'(t));
    end
  end

  // Stage B: arc speeds with the sign of y, blend weight
  logic [DUTY_W-1:0]       slow_q;
  logic [MAG_W-1:0]        slow, l_mag, r_mag;
  logic signed [VAL_W-1:0] l_arc, r_arc;
  logic [MAG_W:0]          alpha2;
  logic                    b_v;
  logic signed [VAL_W-1:0] b_x, b_l_arc, b_r_arc;
  logic [MAG_W:0]          b_alpha;

  always_comb begin
    slow_q = div_unit(PROD_W'(a_prod));
    slow   = slow_q[MAG_W-1:0];
    l_mag  = a_cmd.x_pos ? a_cmd.ay : slow;
    r_mag  = a_cmd.x_pos ? slow : a_cmd.ay;
    if (a_cmd.y_pos) begin
      l_arc = VAL_W'(l_mag);
      r_arc = VAL_W'(r_mag);
    end else if (a_cmd.y_neg) begin
      l_arc = -VAL_W'(l_mag);
      r_arc = -VAL_W'(r_mag);
    end else begin
      l_arc = '0;
      r_arc = '0;
    end
    alpha2 = {a_cmd.ay, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_x     <= a_cmd.x;
      b_l_arc <= l_arc;
      b_r_arc <= r_arc;
      b_alpha <= (alpha2 > (MAG_W+1)'(UNIT)) ? (MAG_W+1)'(UNIT) : alpha2;
    end
  end

  // Stage C: blend sums alpha*arc + (1000-alpha)*tank
  logic signed [SUM_W-1:0] alpha_s, beta_s, x_s;
  logic                    c_v;
  logic signed [SUM_W-1:0] c_l_sum, c_r_sum;

  assign alpha_s = SUM_W'(signed'({1'b0, b_alpha}));
  assign beta_s  = SUM_W'(UNIT) - alpha_s;
  assign x_s     = SUM_W'(b_x);

  always_ff @(posedge clk) begin
    if (adv) begin
      c_l_sum <= alpha_s * SUM_W'(b_l_arc) + beta_s * x_s;
      c_r_sum <= alpha_s * SUM_W'(b_r_arc) - beta_s * x_s;
    end
  end

  // Stage D: targets, truncated toward zero, as sign and magnitude
  logic signed [SUM_W-1:0] l_abs, r_abs;
  logic [DUTY_W-1:0]       l_q, r_q;
  logic                    d_v;
  logic [MAG_W-1:0]        d_l_mag, d_r_mag;
  logic                    d_l_neg, d_r_neg;

  always_comb begin
    l_abs = c_l_sum[SUM_W-1] ? -c_l_sum : c_l_sum;
    r_abs = c_r_sum[SUM_W-1] ? -c_r_sum : c_r_sum;
    l_q   = div_unit(l_abs[PROD_W-1:0]);
    r_q   = div_unit(r_abs[PROD_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_l_mag <= l_q[MAG_W-1:0];
      d_r_mag <= r_q[MAG_W-1:0];
      d_l_neg <= c_l_sum[SUM_W-1] && (l_q != '0);
      d_r_neg <= c_r_sum[SUM_W-1] && (r_q != '0);
    end
  end

  // Stage E: correction products, targets crossed onto the motors
  logic              e_v;
  logic [PROD_W-1:0] e_left_prod, e_right_prod;
  logic              e_left_neg, e_right_neg;

  always_ff @(posedge clk) begin
    if (adv) begin
      e_left_prod  <= PROD_W'(left_corr) * PROD_W'(d_r_mag);
      e_right_prod <= PROD_W'(right_corr) * PROD_W'(d_l_mag);
      e_left_neg   <= d_r_neg;
      e_right_neg  <= d_l_neg;
    end
  end

  // Output register: duty values and direction pins
  always_ff @(posedge clk) begin
    if (adv) begin
      out_res.left_duty    <= div_unit(e_left_prod);
      out_res.left_in_one  <= !e_left_neg;
      out_res.left_in_two  <= e_left_neg;
      out_res.right_duty   <= div_unit(e_right_prod);
      out_res.right_in_one <= !e_right_neg;
      out_res.right_in_two <= e_right_neg;
    end
  end

  // Valid chain behind the divider
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v       <= 1'b0;
      b_v       <= 1'b0;
      c_v       <= 1'b0;
      d_v       <= 1'b0;
      e_v       <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      a_v       <= div_v[DIV_STAGES-1];
      b_v       <= a_v;
      c_v       <= b_v;
      d_v       <= c_v;
      e_v       <= d_v;
      out_valid <= e_v;
    end
  end

endmodule

`default_nettype wire

>>> src/differential_drive_mixer_unit.sv
// Channel      | Dir | Fields (lowest bit up)
// s_axis       | in  | turn_cmd[15:0], throttle_cmd[31:16]
// m_axis       | out | left_in_one, left_in_two, left_duty[11], right_in_one,
//              |     | right_in_two, right_duty[11], zero pad to 32 bits
// cfg          | in  | cfg_index selects left_correction or right_correction
//
// One command per cycle sustained while result beats are taken; the ratio divider
// yields two quotient bits per stage. Synchronous reset clears all valids and the
// queue and sets both corrections to 1000. A held output beat stalls the back end
// as a whole; the two-entry queue and the front register keep taking beats
// until they fill.
// Top level of the differential drive mixer; depends on ddm_pkg, ddm_front,
// ddm_queue and ddm_back.
`default_nettype none

module differential_drive_mixer_unit import ddm_pkg::*; #(
  parameter int FULL_SCALE = 1000
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // turn_cmd[15:0], throttle_cmd[31:16]
  input  wire logic [31:0]        s_axis_tdata,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  // left_in_one[0], left_in_two[1], left_duty[12:2], right_in_one[13],
  // right_in_two[14], right_duty[25:15], zero[31:26]
  output logic [31:0]             m_axis_tdata,
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  input  wire logic               cfg_we,
  input  wire logic [INDEX_W-1:0] cfg_index,
  input  wire logic [CORR_W-1:0]  cfg_data
);

  logic [CORR_W-1:0] left_correction, right_correction;
  logic              f_valid, q_in_ready, q_valid, b_ready;
  cmd_t              f_cmd, q_cmd;
  result_t           res;

  // Correction registers
  always_ff @(posedge clk) begin
    if (rst) begin
      left_correction  <= CORR_RESET;
      right_correction <= CORR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEFT_CORR:  left_correction  <= cfg_data;
        REG_RIGHT_CORR: right_correction <= cfg_data;
        default: ;
      endcase
    end
  end

  ddm_front #(
    .FULL_SCALE(FULL_SCALE)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .turn_cmd    (s_axis_tdata[15:0]),
    .throttle_cmd(s_axis_tdata[31:16]),
    .out_valid   (f_valid),
    .out_ready   (q_in_ready),
    .out_cmd     (f_cmd)
  );

  ddm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (f_valid),
    .in_ready (q_in_ready),
    .in_cmd   (f_cmd),
    .out_valid(q_valid),
    .out_ready(b_ready),
    .out_cmd  (q_cmd)
  );

  ddm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_ready  (b_ready),
    .in_cmd    (q_cmd),
    .left_corr (left_correction),
    .right_corr(right_correction),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (res)
  );

  // Output beat packing
  assign m_axis_tdata = {6'b0, res.right_duty, res.right_in_two, res.right_in_one,
                         res.left_duty, res.left_in_two, res.left_in_one};

endmodule

`default_nettype wire

>>> bench/tb_differential_drive_mixer_unit.sv
// Self-checking bench for differential_drive_mixer_unit: drives joystick beats,
// predicts both motor commands per beat and checks every result beat.
// Depends on ddm_pkg and the mixer RTL.
`default_nettype none

module tb_differential_drive_mixer_unit;
  import ddm_pkg::*;

  localparam int FULL_SCALE = 1000;
  localparam int SETTLE     = 30;      // cycles waited after the last result
  localparam int LIMIT      = 300000;
  localparam int PHASES     = 8;
  localparam int PHASE_CMDS = 200;

  // Expected motor driver outputs of one command
  typedef struct {
    bit              l_one;
    bit              l_two;
    bit [DUTY_W-1:0] l_duty;
    bit              r_one;
    bit              r_two;
    bit [DUTY_W-1:0] r_duty;
  } motor_cmd_t;

  class mixer_scoreboard;
    motor_cmd_t            pending[$];
    bit [CORR_W-1:0]       left_corr  = CORR_RESET;
    bit [CORR_W-1:0]       right_corr = CORR_RESET;
    int                    errors     = 0;

    function void set_correction(logic [INDEX_W-1:0] idx, logic [CORR_W-1:0] value);
      if (idx == REG_LEFT_CORR) left_corr = value;
      else if (idx == REG_RIGHT_CORR) right_corr = value;
    endfunction

    function longint clamp_scale(longint v);
      if (v < -FULL_SCALE) return -FULL_SCALE;
      if (v > FULL_SCALE) return FULL_SCALE;
      return v;
    endfunction

    // direction pins and scaled duty of one motor
    function void motor_drive(longint target, bit [CORR_W-1:0] corr, output bit one,
                              output bit two, output bit [DUTY_W-1:0] duty);
      longint speed;
      speed = (target < 0) ? -target : target;
      if (speed > FULL_SCALE) speed = FULL_SCALE;
      one  = (target >= 0);
      two  = (target < 0);
      duty = DUTY_W'((longint'(corr) * speed) / UNIT);
    endfunction

    // arc/tank blend; targets cross over onto the motors
    function motor_cmd_t mix_command(logic signed [CMD_W-1:0] turn,
                                     logic signed [CMD_W-1:0] thr);
      motor_cmd_t m;
      longint x, y, ax, ay, den, ratio, slow, l_arc, r_arc, dir, alpha, l_tgt, r_tgt;
      x     = clamp_scale(longint'(turn));
      y     = clamp_scale(longint'(thr));
      ax    = (x < 0) ? -x : x;
      ay    = (y < 0) ? -y : y;
      den   = ax + ay;
      ratio = (den > 0) ? (ax * UNIT) / den : 0;
      slow  = (ay * (UNIT - ratio)) / UNIT;
      if (x > 0) begin
        l_arc = ay;
        r_arc = slow;
      end else begin
        l_arc = slow;
        r_arc = ay;
      end
      dir   = (y > 0) ? 1 : ((y < 0) ? -1 : 0);
      l_arc = l_arc * dir;
      r_arc = r_arc * dir;
      alpha = (ay * 2 > UNIT) ? UNIT : ay * 2;
      l_tgt = (alpha * l_arc + (UNIT - alpha) * x) / UNIT;
      r_tgt = (alpha * r_arc + (UNIT - alpha) * (-x)) / UNIT;
      motor_drive(r_tgt, left_corr, m.l_one, m.l_two, m.l_duty);
      motor_drive(l_tgt, right_corr, m.r_one, m.r_two, m.r_duty);
      return m;
    endfunction

    function void note_command(logic signed [CMD_W-1:0] turn, logic signed [CMD_W-1:0] thr);
      pending.push_back(mix_command(turn, thr));
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_beat(logic [31:0] d);
      motor_cmd_t want;
      if (pending.size() == 0) begin
        $error("result beat %h with no command outstanding", d);
        errors++;
        return;
      end
      want = pending.pop_front();
      compare_field("left_in_one",  want.l_one,  d[0]);
      compare_field("left_in_two",  want.l_two,  d[1]);
      compare_field("left_duty",    want.l_duty, d[12:2]);
      compare_field("right_in_one", want.r_one,  d[13]);
      compare_field("right_in_two", want.r_two,  d[14]);
      compare_field("right_duty",   want.r_duty, d[25:15]);
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  // turn_cmd[15:0], throttle_cmd[31:16]
  logic [31:0]         s_axis_tdata = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // left_in_one, left_in_two, left_duty[12:2], right_in_one, right_in_two,
  // right_duty[25:15], zero pad
  logic [31:0]         m_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic                cfg_we = 1'b0;
  logic [INDEX_W-1:0]  cfg_index = REG_LEFT_CORR;
  logic [CORR_W-1:0]   cfg_data = '0;

  mixer_scoreboard book = new();
  bit  tx_idle_on  = 1'b1;
  bit  rx_idle_on  = 1'b1;
  int  hold_cycles = 0;
  int  cycles      = 0;

  differential_drive_mixer_unit #(.FULL_SCALE(FULL_SCALE)) uut (
    .clk(clk), .rst(rst),
    .s_axis_tdata(s_axis_tdata), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // result side: random stalls, long hold-off on request
  initial begin
    forever begin
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready <= 1'b0;
      end else if (rx_idle_on) begin
        m_axis_tready <= ($urandom_range(0, 99) >= 35);
      end else begin
        m_axis_tready <= 1'b1;
      end
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) book.check_beat(m_axis_tdata);
    end
  end

  // offer one command beat, with random gaps ahead of it
  task automatic send_command(input logic signed [CMD_W-1:0] turn,
                              input logic signed [CMD_W-1:0] thr);
    while (tx_idle_on && $urandom_range(0, 99) < 35) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {thr, turn};
    do @(posedge clk); while (!s_axis_tready);
    book.note_command(turn, thr);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (book.pending.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_corrections(input logic [CORR_W-1:0] l, input logic [CORR_W-1:0] r);
    cfg_we    <= 1'b1;
    cfg_index <= REG_LEFT_CORR;
    cfg_data  <= l;
    @(posedge clk);
    book.set_correction(REG_LEFT_CORR, l);
    cfg_index <= REG_RIGHT_CORR;
    cfg_data  <= r;
    @(posedge clk);
    book.set_correction(REG_RIGHT_CORR, r);
    cfg_we <= 1'b0;
  endtask

  // mostly near full scale so clamping edges get hit, sometimes any 16 bits
  function automatic logic [CMD_W-1:0] random_cmd();
    if ($urandom_range(0, 9) < 7) return CMD_W'(int'($urandom_range(0, 2200)) - 1100);
    return CMD_W'($urandom);
  endfunction

  initial begin
    logic [CMD_W-1:0] dir_turn[$];
    logic [CMD_W-1:0] dir_thr[$];
    logic [CORR_W-1:0] l, r;
    dir_turn = '{16'sd0, 16'sh7FFF, 16'sh8000, 16'sd1000, -16'sd1000, 16'sd0, 16'sd0,
                 16'sd1001, 16'sd500, -16'sd500, 16'sd500, -16'sd500, 16'sd1, -16'sd1,
                 16'sd0, 16'sd0, 16'sd300, 16'sd300, -16'sd7, 16'sd999, 16'sh8000,
                 16'sd5, 16'sd1, -16'sd1};
    dir_thr  = '{16'sd0, 16'sh7FFF, 16'sh8000, 16'sd0, 16'sd0, 16'sd1000, -16'sd1000,
                 -16'sd1001, 16'sd250, 16'sd250, -16'sd250, -16'sd250, 16'sd1, -16'sd1,
                 16'sd1, -16'sd1, 16'sd499, 16'sd500, 16'sd3, -16'sd2, 16'sd5,
                 16'sh7FFF, -16'sd1, 16'sd1};

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners under reset corrections
    foreach (dir_turn[i]) send_command(dir_turn[i], dir_thr[i]);
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          l = 11'd0;
          r = 11'd2047;
        end
        1: begin
          l = 11'd2047;
          r = 11'd0;
        end
        2: begin
          l = 11'd2000;
          r = 11'd2000;
        end
        3: begin
          l = 11'd1000;
          r = 11'd1;
        end
        default: begin
          l = CORR_W'($urandom_range(0, 2047));
          r = CORR_W'($urandom_range(0, 2047));
        end
      endcase
      write_corrections(l, r);
      // phase 2 runs with no idling on either side
      tx_idle_on = (ph != 2);
      rx_idle_on = (ph != 2);
      // phase 4: receiver holds off while commands keep coming
      if (ph == 4) hold_cycles = 400;
      repeat (PHASE_CMDS) send_command(random_cmd(), random_cmd());
      // the first three corners again under the new corrections, phases 0 to 3 only
      if (ph < 4) begin
        for (int i = 0; i < 3; i++) send_command(dir_turn[i], dir_thr[i]);
      end
      wait_drained();
    end

    if (book.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
